// ----- design/jjs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jjs_pkg
// Shared constants and types of the joint jerk smoothness unit.
// ----------------------------------------------------------------------------
package jjs_pkg;

	localparam int MAXJ       = 6;
	localparam int JOINTS_DEF = 6;
	localparam int JIW        = 3;
	localparam int POS_W      = 32;
	localparam int JERK_W     = 48;
	localparam int SUM_W      = 64;
	localparam int WGT_W      = 16;
	localparam int DIFF_W     = 36;

	localparam int MUL_AW = 96;
	localparam int MUL_BW = 48;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_SAMPLE = 2'd1;
	localparam logic [1:0] CMD_WEIGHT = 2'd2;

	localparam logic [1:0] CFG_JOINTS = 2'd0;
	localparam logic [1:0] CFG_INVDT  = 2'd1;
	localparam logic [1:0] CFG_DTS    = 2'd2;

	localparam logic [2:0]  JUSED_RST = 3'd1;
	localparam logic [47:0] INVDT_RST = 48'd65536000000;
	localparam logic [31:0] DTS_RST   = 32'd655;
	localparam logic [15:0] W_ONE     = 16'd256;

	typedef struct packed {
		logic              start;
		logic [MUL_AW-1:0] a;
		logic [MUL_BW-1:0] b;
		logic [1:0]        a_last;
		logic              b_last;
	} mul_req_t;

endpackage

// ----- design/jjs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jjs_ram
// Single write, single read synchronous memory with per-entry valid bits.
// ----------------------------------------------------------------------------
module jjs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 18,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata,
	output logic             rhit
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rhit  <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rhit <= vld_q[raddr];
			end
		end
	end

endmodule

// ----- design/jjs_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jjs_mul
// Shared unsigned multiplier: one 32x32 partial product per cycle, registered,
// then shifted into a wide accumulator.
// ----------------------------------------------------------------------------
module jjs_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  jjs_pkg::mul_req_t          req,
	output logic [jjs_pkg::MUL_PW-1:0] prod,
	output logic                       done
);

	logic [jjs_pkg::MUL_AW-1:0] a_q;
	logic [jjs_pkg::MUL_BW-1:0] b_q;
	logic [1:0]                 a_last_q;
	logic                       b_last_q;
	logic [1:0]                 ia_q;
	logic                       ib_q;
	logic                       run_q;
	logic                       done_q;
	logic [63:0]                pp_s1;
	logic [1:0]                 off_s1;
	logic                       v_s1;
	logic                       last_s1;
	logic [jjs_pkg::MUL_PW-1:0] acc_q;
	logic [31:0]                limb_a;
	logic [31:0]                limb_b;
	logic [jjs_pkg::MUL_PW-1:0] ext;

	always_comb begin
		case (ia_q)
			2'd0:    limb_a = a_q[31:0];
			2'd1:    limb_a = a_q[63:32];
			default: limb_a = a_q[95:64];
		endcase
		limb_b = ib_q ? {16'd0, b_q[47:32]} : b_q[31:0];
	end

	always_comb begin
		case (off_s1)
			2'd0:    ext = {80'd0, pp_s1};
			2'd1:    ext = {48'd0, pp_s1, 32'd0};
			2'd2:    ext = {16'd0, pp_s1, 64'd0};
			default: ext = {pp_s1[47:0], 96'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			ia_q     <= 2'd0;
			ib_q     <= 1'b0;
			v_s1     <= 1'b0;
			last_s1  <= 1'b0;
			done_q   <= 1'b0;
			a_last_q <= 2'd0;
			b_last_q <= 1'b0;
		end else begin
			v_s1    <= run_q;
			last_s1 <= run_q && ia_q == a_last_q && ib_q == b_last_q;
			done_q  <= v_s1 && last_s1;
			if (req.start) begin
				run_q    <= 1'b1;
				ia_q     <= 2'd0;
				ib_q     <= 1'b0;
				a_last_q <= req.a_last;
				b_last_q <= req.b_last;
			end else if (run_q) begin
				if (ib_q == b_last_q) begin
					ib_q <= 1'b0;
					if (ia_q == a_last_q) begin
						run_q <= 1'b0;
					end else begin
						ia_q <= ia_q + 2'd1;
					end
				end else begin
					ib_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		pp_s1  <= limb_a * limb_b;
		off_s1 <= ia_q + {1'b0, ib_q};
		if (req.start) begin
			acc_q <= '0;
		end else if (v_s1) begin
			acc_q <= acc_q + ext;
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

// ----- design/joint_jerk_smoothness_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_jerk_smoothness_unit
// Third-difference jerk per joint and saturating weighted jerk cost.
//
//  channel | dir | handshake            | payload
//  in      | in  | in_valid / in_ready  | cmd, pos_0..5, weight_row/col/value
//  out     | out | out_valid / out_ready| jerk_0..5, jerk_valid, smoothness
//  cfg     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item at a time. Start, weight write and other commands go straight to the
// smoothness multiply. A sample reads history for every joint through the single
// read port of its memory, then runs the jerk and weighted-sum products of the n
// joints in use (none before the fourth sample) on the shared 32x32 multiplier.
// History and weights sit in memories with valid bits; reset needs no sweep.
// The output register lets a result wait while the next item is worked on.
// ----------------------------------------------------------------------------
module joint_jerk_smoothness_unit #(
	parameter int JOINTS = jjs_pkg::JOINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] pos_0,
	input  logic signed [31:0] pos_1,
	input  logic signed [31:0] pos_2,
	input  logic signed [31:0] pos_3,
	input  logic signed [31:0] pos_4,
	input  logic signed [31:0] pos_5,
	input  logic [2:0]         weight_row,
	input  logic [2:0]         weight_col,
	input  logic signed [15:0] weight_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [47:0] jerk_0,
	output logic signed [47:0] jerk_1,
	output logic signed [47:0] jerk_2,
	output logic signed [47:0] jerk_3,
	output logic signed [47:0] jerk_4,
	output logic signed [47:0] jerk_5,
	output logic               jerk_valid,
	output logic signed [63:0] smoothness,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [47:0]        cfg_data
);

	localparam int HDEPTH = 3 * JOINTS;
	localparam int HAW    = $clog2(HDEPTH);
	localparam int WDEPTH = jjs_pkg::MAXJ * jjs_pkg::MAXJ;
	localparam int WAW    = $clog2(WDEPTH);
	localparam int NJ     = jjs_pkg::MAXJ;

	typedef enum logic [3:0] {
		S_IDLE, S_HRD0, S_HRD1, S_HRD2, S_HD, S_JMUL, S_JWAIT, S_QRD,
		S_QM1, S_QW1, S_QM2, S_QW2, S_SMUL, S_SWAIT, S_DONE
	} state_t;

	state_t state_q;

	logic [2:0]  jused_q;
	logic [47:0] invdt_q;
	logic [31:0] dts_q;

	logic [31:0] pos_q  [NJ];
	logic [47:0] jerk_q [NJ];
	logic [1:0]  head_q;
	logic [1:0]  seen_q;
	logic [63:0] sum_q;
	logic        item_ok_q;
	logic [2:0]  ji_q;
	logic [2:0]  jj_q;
	logic [31:0] p2_q;
	logic [31:0] p1_q;
	logic [35:0] d_q;
	logic [15:0] w_q;
	logic [95:0] m1_q;
	logic [63:0] smooth_q;

	logic        in_fire;
	logic [2:0]  n_act;
	logic        last_joint;

	logic            h_clr;
	logic            h_we;
	logic [HAW-1:0]  h_waddr;
	logic [31:0]     h_wdata;
	logic            h_re;
	logic [HAW-1:0]  h_raddr;
	logic [31:0]     h_rdata;
	logic            h_rhit;
	logic [31:0]     hp;

	logic            w_we;
	logic [WAW-1:0]  w_waddr;
	logic            w_re;
	logic [WAW-1:0]  w_raddr;
	logic [15:0]     w_rdata;
	logic            w_rhit;
	logic [15:0]     wv;

	jjs_pkg::mul_req_t             mreq;
	logic [jjs_pkg::MUL_PW-1:0]    mprod;
	logic                          mdone;

	logic signed [35:0] cur_x, p2_x, p1_x, p0_x, d_next;
	logic [35:0]  dmag;
	logic [47:0]  jmag_i, jmag_j;
	logic [15:0]  wmag;
	logic [63:0]  summag;
	logic [143:0] jsh, tsh, ssh;
	logic         jneg, tneg, sneg;
	logic [47:0]  jlim, jmag_sat, jerk_new;
	logic [63:0]  tlim, tmag, slim, smag, smooth_new;
	logic [64:0]  term;
	logic [65:0]  s66;
	logic [63:0]  sum_new;

	function automatic logic [1:0] nxt3(input logic [1:0] h);
		nxt3 = (h == 2'd2) ? 2'd0 : h + 2'd1;
	endfunction

	function automatic logic [1:0] prv3(input logic [1:0] h);
		prv3 = (h == 2'd0) ? 2'd2 : h - 2'd1;
	endfunction

	function automatic logic [HAW-1:0] haddr(input logic [1:0] s, input logic [2:0] j);
		haddr = HAW'(int'(s) * JOINTS + int'(j));
	endfunction

	function automatic logic [WAW-1:0] waddr_of(input logic [2:0] r, input logic [2:0] c);
		waddr_of = WAW'(int'(r) * jjs_pkg::MAXJ + int'(c));
	endfunction

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (jused_q == 3'd0) begin
			n_act = 3'd1;
		end else if (int'(jused_q) > JOINTS) begin
			n_act = 3'(JOINTS);
		end else begin
			n_act = jused_q;
		end
	end

	assign last_joint = (int'(ji_q) == JOINTS - 1);

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jused_q <= jjs_pkg::JUSED_RST;
			invdt_q <= jjs_pkg::INVDT_RST;
			dts_q   <= jjs_pkg::DTS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				jjs_pkg::CFG_JOINTS: jused_q <= cfg_data[2:0];
				jjs_pkg::CFG_INVDT:  invdt_q <= cfg_data;
				jjs_pkg::CFG_DTS:    dts_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// memories
	assign h_clr   = in_fire && cmd == jjs_pkg::CMD_START;
	assign h_we    = (state_q == S_HD);
	assign h_waddr = haddr(nxt3(head_q), ji_q);
	assign h_wdata = pos_q[ji_q];
	assign h_re    = (state_q == S_HRD0) || (state_q == S_HRD1) || (state_q == S_HRD2);

	always_comb begin
		case (state_q)
			S_HRD0:  h_raddr = haddr(head_q, ji_q);
			S_HRD1:  h_raddr = haddr(prv3(head_q), ji_q);
			default: h_raddr = haddr(nxt3(head_q), ji_q);
		endcase
	end

	assign hp = h_rhit ? h_rdata : 32'd0;

	assign w_we    = in_fire && cmd == jjs_pkg::CMD_WEIGHT
		&& int'(weight_row) < jjs_pkg::MAXJ && int'(weight_col) < jjs_pkg::MAXJ;
	assign w_waddr = waddr_of(weight_row, weight_col);
	assign w_re    = (state_q == S_QRD);
	assign w_raddr = waddr_of(ji_q, jj_q);
	assign wv      = w_rhit ? w_rdata : ((ji_q == jj_q) ? jjs_pkg::W_ONE : 16'd0);

	jjs_ram #(.WIDTH(32), .DEPTH(HDEPTH)) u_hist (
		.clk(clk), .arst_n(arst_n), .clr(h_clr),
		.we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.re(h_re), .raddr(h_raddr), .rdata(h_rdata), .rhit(h_rhit)
	);

	jjs_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_wtab (
		.clk(clk), .arst_n(arst_n), .clr(1'b0),
		.we(w_we), .waddr(w_waddr), .wdata(weight_value),
		.re(w_re), .raddr(w_raddr), .rdata(w_rdata), .rhit(w_rhit)
	);

	// arithmetic
	always_comb begin
		cur_x  = 36'(signed'(pos_q[ji_q]));
		p2_x   = 36'(signed'(p2_q));
		p1_x   = 36'(signed'(p1_q));
		p0_x   = 36'(signed'(hp));
		d_next = cur_x - (p2_x <<< 1) - p2_x + (p1_x <<< 1) + p1_x - p0_x;
		dmag   = d_q[35] ? 36'(-d_q) : d_q;
		jmag_i = jerk_q[ji_q][47] ? 48'(-jerk_q[ji_q]) : jerk_q[ji_q];
		jmag_j = jerk_q[jj_q][47] ? 48'(-jerk_q[jj_q]) : jerk_q[jj_q];
		wmag   = w_q[15] ? 16'(-w_q) : w_q;
		summag = sum_q[63] ? 64'(-sum_q) : sum_q;

		jsh      = mprod >> 16;
		jneg     = d_q[35];
		jlim     = jneg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
		jmag_sat = (|jsh[143:48] || jsh[47:0] > jlim) ? jlim : jsh[47:0];
		jerk_new = jneg ? 48'(-jmag_sat) : jmag_sat;

		tsh  = mprod >> 24;
		tneg = jerk_q[ji_q][47] ^ jerk_q[jj_q][47] ^ w_q[15];
		tlim = tneg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		tmag = (|tsh[143:64] || tsh[63:0] > tlim) ? tlim : tsh[63:0];
		term = tneg ? 65'(-{1'b0, tmag}) : {1'b0, tmag};
		s66  = {{2{sum_q[63]}}, sum_q} + {term[64], term};
		if (s66[65:63] == 3'b000 || s66[65:63] == 3'b111) begin
			sum_new = s66[63:0];
		end else begin
			sum_new = s66[65] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end

		ssh        = mprod >> 16;
		sneg       = sum_q[63];
		slim       = sneg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		smag       = (|ssh[143:64] || ssh[63:0] > slim) ? slim : ssh[63:0];
		smooth_new = sneg ? 64'(-smag) : smag;
	end

	always_comb begin
		mreq = '0;
		unique case (state_q)
			S_JMUL: begin
				mreq.start  = 1'b1;
				mreq.a      = 96'(dmag);
				mreq.b      = invdt_q;
				mreq.a_last = 2'd1;
				mreq.b_last = 1'b1;
			end
			S_QM1: begin
				mreq.start  = 1'b1;
				mreq.a      = 96'(jmag_i);
				mreq.b      = jmag_j;
				mreq.a_last = 2'd1;
				mreq.b_last = 1'b1;
			end
			S_QM2: begin
				mreq.start  = 1'b1;
				mreq.a      = m1_q;
				mreq.b      = 48'(wmag);
				mreq.a_last = 2'd2;
				mreq.b_last = 1'b0;
			end
			S_SMUL: begin
				mreq.start  = 1'b1;
				mreq.a      = 96'(summag);
				mreq.b      = 48'(dts_q);
				mreq.a_last = 2'd1;
				mreq.b_last = 1'b0;
			end
			default: ;
		endcase
	end

	jjs_mul u_mul (
		.clk(clk), .arst_n(arst_n), .req(mreq), .prod(mprod), .done(mdone)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= 2'd0;
			seen_q     <= 2'd0;
			sum_q      <= '0;
			item_ok_q  <= 1'b0;
			ji_q       <= 3'd0;
			jj_q       <= 3'd0;
			p2_q       <= '0;
			p1_q       <= '0;
			d_q        <= '0;
			w_q        <= '0;
			m1_q       <= '0;
			smooth_q   <= '0;
			out_valid  <= 1'b0;
			jerk_valid <= 1'b0;
			smoothness <= '0;
			jerk_0     <= '0;
			jerk_1     <= '0;
			jerk_2     <= '0;
			jerk_3     <= '0;
			jerk_4     <= '0;
			jerk_5     <= '0;
			for (int k = 0; k < NJ; k++) begin
				pos_q[k]  <= '0;
				jerk_q[k] <= '0;
			end
		end else begin
			if (out_valid && out_ready && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						pos_q[0] <= pos_0;
						pos_q[1] <= pos_1;
						pos_q[2] <= pos_2;
						pos_q[3] <= pos_3;
						pos_q[4] <= pos_4;
						pos_q[5] <= pos_5;
						for (int k = 0; k < NJ; k++) begin
							jerk_q[k] <= '0;
						end
						ji_q      <= 3'd0;
						jj_q      <= 3'd0;
						item_ok_q <= (cmd == jjs_pkg::CMD_SAMPLE) && (seen_q == 2'd3);
						if (cmd == jjs_pkg::CMD_START) begin
							sum_q  <= '0;
							seen_q <= 2'd0;
							head_q <= 2'd0;
						end
						state_q <= (cmd == jjs_pkg::CMD_SAMPLE) ? S_HRD0 : S_SMUL;
					end
				end
				S_HRD0: state_q <= S_HRD1;
				S_HRD1: begin
					p2_q    <= hp;
					state_q <= S_HRD2;
				end
				S_HRD2: begin
					p1_q    <= hp;
					state_q <= S_HD;
				end
				S_HD: begin
					d_q <= d_next;
					if (item_ok_q && ji_q < n_act) begin
						state_q <= S_JMUL;
					end else if (last_joint) begin
						head_q  <= nxt3(head_q);
						seen_q  <= (seen_q == 2'd3) ? seen_q : seen_q + 2'd1;
						ji_q    <= 3'd0;
						state_q <= item_ok_q ? S_QRD : S_SMUL;
					end else begin
						ji_q    <= ji_q + 3'd1;
						state_q <= S_HRD0;
					end
				end
				S_JMUL: state_q <= S_JWAIT;
				S_JWAIT: begin
					if (mdone) begin
						jerk_q[ji_q] <= jerk_new;
						if (last_joint) begin
							head_q  <= nxt3(head_q);
							seen_q  <= (seen_q == 2'd3) ? seen_q : seen_q + 2'd1;
							ji_q    <= 3'd0;
							state_q <= S_QRD;
						end else begin
							ji_q    <= ji_q + 3'd1;
							state_q <= S_HRD0;
						end
					end
				end
				S_QRD: state_q <= S_QM1;
				S_QM1: begin
					w_q     <= wv;
					state_q <= S_QW1;
				end
				S_QW1: begin
					if (mdone) begin
						m1_q    <= mprod[95:0];
						state_q <= S_QM2;
					end
				end
				S_QM2: state_q <= S_QW2;
				S_QW2: begin
					if (mdone) begin
						sum_q <= sum_new;
						if (jj_q == n_act - 3'd1) begin
							jj_q <= 3'd0;
							if (ji_q == n_act - 3'd1) begin
								state_q <= S_SMUL;
							end else begin
								ji_q    <= ji_q + 3'd1;
								state_q <= S_QRD;
							end
						end else begin
							jj_q    <= jj_q + 3'd1;
							state_q <= S_QRD;
						end
					end
				end
				S_SMUL: state_q <= S_SWAIT;
				S_SWAIT: begin
					if (mdone) begin
						smooth_q <= smooth_new;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid  <= 1'b1;
						jerk_0     <= jerk_q[0];
						jerk_1     <= jerk_q[1];
						jerk_2     <= jerk_q[2];
						jerk_3     <= jerk_q[3];
						jerk_4     <= jerk_q[4];
						jerk_5     <= jerk_q[5];
						jerk_valid <= item_ok_q;
						smoothness <= smooth_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !mdone)
		else $error("multiplier finished with no work pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != S_IDLE)
		else $error("item accepted but sequencer stayed idle");

	a_seen_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_fire && cmd == jjs_pkg::CMD_START) |=> seen_q >= $past(seen_q))
		else $error("sample count dropped without a start");

	a_quad_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_QRD |-> item_ok_q && seen_q == 2'd3)
		else $error("weighted sum entered without full history");

endmodule
